/* rtl/core/bdd_pkg.sv */
// Package for the baud divisor decoder: payload structs, clock constants,
// fraction table and the controller/datapath command and status structs.
// No dependencies.
`default_nettype none

package bdd_pkg;

	localparam int unsigned VALUE_W = 16;
	localparam int unsigned INDEX_W = 16;
	localparam int unsigned BAUD_W  = 24;
	localparam int unsigned SPEED_W = 28;
	localparam int unsigned NUM_W   = 28;
	localparam int unsigned DEN_W   = 18;
	localparam int unsigned DIVD_W  = 17;
	localparam int unsigned RATIO_W = 5;

	// Numerator is 16 * clock, for the 12 MHz and 3 MHz clocks.
	localparam logic [NUM_W-1:0] NUM_HIGH_CLOCK = NUM_W'(16 * 12000000);
	localparam logic [NUM_W-1:0] NUM_BASE_CLOCK = NUM_W'(16 * 3000000);
	localparam logic [NUM_W-1:0] BAUD_MAX       = NUM_W'(12000000);
	localparam logic [BAUD_W-1:0] BAUD_RESET    = BAUD_W'(115200);

	localparam int unsigned RATIO_HIGH_CLOCK = 1;
	localparam int unsigned RATIO_BASE_CLOCK = 1;

	// Interface numbers that take a rate change.
	localparam logic [7:0] IFACE_A = 8'h00;
	localparam logic [7:0] IFACE_B = 8'h01;

	// Divisor stand-ins, in eighths: one for a zero divisor, one-and-a-half for a divisor of one.
	localparam logic [DIVD_W-1:0] DIVD_ZERO    = DIVD_W'(8);
	localparam logic [DIVD_W-1:0] DIVD_ONEHALF = DIVD_W'(12);

	localparam int unsigned DIV_STEPS = NUM_W;
	localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

	typedef struct packed {
		logic [VALUE_W-1:0] value_word;
		logic [INDEX_W-1:0] index_word;
	} bdd_in_t;

	typedef struct packed {
		logic               accepted;
		logic [BAUD_W-1:0]  baud_rate;
		logic [SPEED_W-1:0] bitbang_speed;
	} bdd_out_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic sat;
		logic mul;
		logic commit;
	} bdd_cmd_t;

	typedef struct packed {
		logic iface_ok;
	} bdd_stat_t;

	// Fraction code to eighths.
	function automatic logic [2:0] frac_eighths(input logic [2:0] code);
		logic [2:0] f;
		case (code)
			3'd0: f = 3'd0;
			3'd1: f = 3'd4;
			3'd2: f = 3'd2;
			3'd3: f = 3'd1;
			3'd4: f = 3'd3;
			3'd5: f = 3'd5;
			3'd6: f = 3'd6;
			3'd7: f = 3'd7;
			default: f = 3'd0;
		endcase
		return f;
	endfunction

endpackage

`default_nettype wire

/* rtl/core/bdd_datapath.sv */
// Datapath of the baud divisor decoder: divisor decode, restoring divider,
// saturation, ratio multiply, stored rate and output register. Uses bdd_pkg.
`default_nettype none

module bdd_datapath (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire bdd_pkg::bdd_in_t in_data,
	input  wire bdd_pkg::bdd_cmd_t cmd,
	output bdd_pkg::bdd_stat_t    stat,
	output bdd_pkg::bdd_out_t     out_data
);
	import bdd_pkg::*;

	logic [13:0]        n_w;
	logic [2:0]         f_w;
	logic [DIVD_W-1:0]  d_w;
	logic               hi_clk_w;
	logic [NUM_W-1:0]   num_w;
	logic [DEN_W:0]     trial_w;
	logic               fits_w;
	logic [BAUD_W-1:0]  sat_w;
	logic [RATIO_W-1:0] ratio_w;
	logic [BAUD_W+RATIO_W-1:0] prod_w;

	logic               acc_q;
	logic               hi_clk_q;
	logic [DEN_W-1:0]   den_q;
	logic [DEN_W-1:0]   rem_q;
	logic [NUM_W-1:0]   quot_q;
	logic [BAUD_W-1:0]  baud_q;
	logic [SPEED_W-1:0] speed_q;
	logic [BAUD_W-1:0]  cur_baud_q;
	logic [SPEED_W-1:0] cur_speed_q;
	bdd_out_t           out_q;

	// Decode the request
	assign stat.iface_ok = (in_data.index_word[7:0] == IFACE_A) ||
		(in_data.index_word[7:0] == IFACE_B);
	assign hi_clk_w = in_data.index_word[9];
	assign n_w      = in_data.value_word[13:0];
	assign f_w      = frac_eighths({in_data.index_word[8], in_data.value_word[15:14]});

	always_comb begin
		if (f_w == 3'd0 && n_w == 14'd0) begin
			d_w = DIVD_ZERO;
		end else if (f_w == 3'd0 && n_w == 14'd1) begin
			d_w = DIVD_ONEHALF;
		end else begin
			d_w = {n_w, f_w};
		end
		num_w = (hi_clk_w ? NUM_HIGH_CLOCK : NUM_BASE_CLOCK) + NUM_W'(d_w);
	end

	// One restoring division step
	assign trial_w = {rem_q, quot_q[NUM_W-1]};
	assign fits_w  = trial_w >= {1'b0, den_q};

	// Saturate and scale
	assign sat_w   = (quot_q > BAUD_MAX) ? BAUD_MAX[BAUD_W-1:0] : quot_q[BAUD_W-1:0];
	assign ratio_w = hi_clk_q ? RATIO_W'(RATIO_HIGH_CLOCK) : RATIO_W'(RATIO_BASE_CLOCK);
	assign prod_w  = (BAUD_W+RATIO_W)'(baud_q) * (BAUD_W+RATIO_W)'(ratio_w);

	// Working registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			acc_q    <= stat.iface_ok;
			hi_clk_q <= hi_clk_w;
			den_q    <= {d_w, 1'b0};
			rem_q    <= '0;
			quot_q   <= num_w;
		end
		if (cmd.div_step) begin
			if (fits_w) begin
				rem_q <= DEN_W'(trial_w - {1'b0, den_q});
			end else begin
				rem_q <= trial_w[DEN_W-1:0];
			end
			quot_q <= {quot_q[NUM_W-2:0], fits_w};
		end
		if (cmd.sat) begin
			baud_q <= sat_w;
		end
		if (cmd.mul) begin
			speed_q <= prod_w[SPEED_W-1:0];
		end
		if (cmd.commit) begin
			out_q.accepted      <= acc_q;
			out_q.baud_rate     <= acc_q ? baud_q : cur_baud_q;
			out_q.bitbang_speed <= acc_q ? speed_q : cur_speed_q;
		end
	end

	// Stored rate and speed
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_baud_q  <= BAUD_RESET;
			cur_speed_q <= '0;
		end else if (cmd.commit && acc_q) begin
			cur_baud_q  <= baud_q;
			cur_speed_q <= speed_q;
		end
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

/* rtl/core/bdd_ctrl.sv */
// Controller of the baud divisor decoder: sequences load, division steps,
// saturation, multiply and commit, and owns both handshakes. Uses bdd_pkg.
`default_nettype none

module bdd_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire bdd_pkg::bdd_stat_t stat,
	output bdd_pkg::bdd_cmd_t       cmd
);
	import bdd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_SAT,
		ST_MUL,
		ST_DONE
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             out_valid_q;
	logic             slot_free;

	assign slot_free  = !out_valid_q || out_ready;
	assign in_ready   = (state_q == ST_IDLE);
	assign out_valid  = out_valid_q;

	// Commands from the current state
	always_comb begin
		cmd          = '0;
		cmd.load     = (state_q == ST_IDLE) && in_valid;
		cmd.div_step = (state_q == ST_DIV);
		cmd.sat      = (state_q == ST_SAT);
		cmd.mul      = (state_q == ST_MUL);
		cmd.commit   = (state_q == ST_DONE) && slot_free;
	end

	// Advance the sequence and hold the output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (in_valid) begin
						state_q <= stat.iface_ok ? ST_DIV : ST_DONE;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_SAT;
					end
				end
				ST_SAT: begin
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* rtl/core/baud_divisor_decoder.sv */
// Top level of the baud divisor decoder: joins controller and datapath.
// Uses bdd_pkg, bdd_ctrl and bdd_datapath.
//
// Input channel (in_valid/in_ready/in_data) takes one set-baud-rate request:
// a value word and an index word. Output channel (out_valid/out_ready/
// out_data) returns one item per request: the accepted flag and the stored
// baud rate and bit-bang speed after the request.
// A request for an interface other than 0 or 1 is refused and returns the
// unchanged stored values without going through the divider.
// An accepted request is decoded into a divisor, and the rate is found by a
// restoring divider that retires one quotient bit a cycle, followed by a
// saturation step and a ratio multiply step. One request is in work at a
// time; the next is taken once the previous result is in the output
// register.
// If the receiver stalls, the result holds in the output register; a new
// request may already be worked on and waits before commit until the
// register is free.
// Reset sets the stored rate to 115200 baud and the speed to zero, and
// leaves no item pending.
`default_nettype none

module baud_divisor_decoder (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire bdd_pkg::bdd_in_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output bdd_pkg::bdd_out_t      out_data
);
	import bdd_pkg::*;

	bdd_cmd_t  cmd;
	bdd_stat_t stat;

	// Sequence the request
	bdd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Decode, divide and store
	bdd_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_data  (in_data),
		.cmd      (cmd),
		.stat     (stat),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

/* verif/baud_divisor_decoder_check.sv */
// Checker for the baud divisor decoder: watches both channels, predicts the
// stored baud rate and bit-bang speed for each request and compares results.
// Depends on bdd_pkg for the payload structs, interface numbers and ratios.
`timescale 1ns / 1ps

module baud_divisor_decoder_check (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  bdd_pkg::bdd_in_t  in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  bdd_pkg::bdd_out_t out_data,
	output int                fail_count,
	output int                pending,
	output int                checked,
	output int                rate_changes
);
	import bdd_pkg::*;

	localparam longint unsigned CLK_HIGH_HZ  = 12000000;
	localparam longint unsigned CLK_BASE_HZ  = 3000000;
	localparam longint unsigned RATE_CEILING = 12000000;
	localparam logic [23:0]     RATE_AT_RESET = 24'd115200;
	// Fraction code to eighths, three bits per code, code 0 in the low bits.
	localparam logic [23:0] EIGHTHS_BY_CODE =
		{3'd7, 3'd6, 3'd5, 3'd3, 3'd1, 3'd2, 3'd4, 3'd0};

	logic [BAUD_W-1:0]  stored_baud;
	logic [SPEED_W-1:0] stored_speed;
	bdd_out_t           expected_status[$];

	// Rate for a 24-bit encoded divisor, rounded half up, capped at 12 MHz.
	function automatic logic [BAUD_W-1:0] divisor_to_rate(input logic [23:0] enc);
		longint unsigned clk_hz;
		longint unsigned n;
		longint unsigned f;
		longint unsigned d;
		longint unsigned rate;
		clk_hz = enc[17] ? CLK_HIGH_HZ : CLK_BASE_HZ;
		n = 64'(enc[13:0]);
		f = 64'(EIGHTHS_BY_CODE[enc[16:14]*3 +: 3]);
		if (n == 0 && f == 0) begin
			rate = clk_hz;
		end else begin
			d = (f == 0 && n == 1) ? 64'd12 : 8 * n + f;
			rate = (16 * clk_hz + d) / (2 * d);
		end
		if (rate > RATE_CEILING) begin
			rate = RATE_CEILING;
		end
		return rate[BAUD_W-1:0];
	endfunction

	// Apply one request to the stored rate and speed; return the status it yields.
	function automatic bdd_out_t decode_request(input bdd_in_t req);
		bdd_out_t st;
		logic [23:0] enc;
		longint unsigned ratio;
		longint unsigned prod;
		st.accepted = 1'b0;
		if (req.index_word[7:0] == IFACE_A || req.index_word[7:0] == IFACE_B) begin
			enc = {req.index_word[15:8], req.value_word};
			ratio = 64'(enc[17] ? RATIO_HIGH_CLOCK : RATIO_BASE_CLOCK);
			stored_baud = divisor_to_rate(enc);
			prod = longint'(stored_baud) * ratio;
			stored_speed = prod[SPEED_W-1:0];
			st.accepted = 1'b1;
		end
		st.baud_rate = stored_baud;
		st.bitbang_speed = stored_speed;
		return st;
	endfunction

	// Predict on each accepted request, compare on each accepted result.
	always @(posedge clk or negedge arst_n) begin
		bdd_out_t want;
		if (!arst_n) begin
			stored_baud = RATE_AT_RESET;
			stored_speed = '0;
			expected_status.delete();
			fail_count = 0;
			pending = 0;
			checked = 0;
			rate_changes = 0;
		end else begin
			if (in_valid && in_ready) begin
				want = decode_request(in_data);
				if (want.accepted) begin
					rate_changes++;
				end
				expected_status.push_back(want);
			end
			if (out_valid && out_ready) begin
				if (expected_status.size() == 0) begin
					$display("%0t: result with no request waiting: %p", $time, out_data);
					fail_count++;
				end else begin
					want = expected_status.pop_front();
					checked++;
					if (out_data.accepted !== want.accepted) begin
						$display("%0t: accepted expected %0d actual %0d",
							$time, want.accepted, out_data.accepted);
						fail_count++;
					end
					if (out_data.baud_rate !== want.baud_rate) begin
						$display("%0t: baud_rate expected %0d actual %0d",
							$time, want.baud_rate, out_data.baud_rate);
						fail_count++;
					end
					if (out_data.bitbang_speed !== want.bitbang_speed) begin
						$display("%0t: bitbang_speed expected %0d actual %0d",
							$time, want.bitbang_speed, out_data.bitbang_speed);
						fail_count++;
					end
				end
			end
			pending = expected_status.size();
		end
	end

endmodule

/* verif/baud_divisor_decoder_test.sv */
// Testbench top for the baud divisor decoder: clock, reset, request stimulus,
// receiver stalls and verdict. Depends on bdd_pkg, baud_divisor_decoder and
// baud_divisor_decoder_check.
`timescale 1ns / 1ps

module baud_divisor_decoder_test;
	import bdd_pkg::*;

	localparam int RANDOM_REQUESTS = 1400;
	localparam int DRAIN_LIMIT     = 5000;

	typedef enum logic [1:0] {
		READY_ALWAYS,
		READY_COIN,
		READY_SPARSE,
		READY_COMB
	} stall_mode_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	bdd_in_t     in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	bdd_out_t    out_data;

	int          fail_count;
	int          pending;
	int          checked;
	int          rate_changes;
	int          requests_sent = 0;
	int          burst_left = 1;
	stall_mode_t stall_mode = READY_ALWAYS;
	logic [7:0]  stall_tick = '0;

	baud_divisor_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	baud_divisor_decoder_check checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.checked      (checked),
		.rate_changes (rate_changes)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Receiver: switch stall pattern each time the 8-bit stall tick wraps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			stall_tick <= '0;
		end else begin
			stall_tick <= stall_tick + 8'd1;
			if (stall_tick == 8'd0) begin
				stall_mode <= stall_mode_t'($urandom_range(0, 3));
			end
			case (stall_mode)
				READY_ALWAYS: out_ready <= 1'b1;
				READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
				READY_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
				default:      out_ready <= (stall_tick[4:3] != 2'b00);
			endcase
		end
	end

	// Build a request from an interface number and a 24-bit encoded divisor.
	function automatic bdd_in_t make_request(input logic [7:0] iface, input logic [23:0] enc);
		bdd_in_t req;
		req.value_word = enc[15:0];
		req.index_word = {enc[23:16], iface};
		return req;
	endfunction

	// Mostly valid interfaces with small divisors favored; the rest refused.
	function automatic bdd_in_t random_request();
		logic [7:0]  iface;
		logic [13:0] n;
		int          pick;
		pick = $urandom_range(0, 99);
		if (pick < 20) begin
			iface = 8'($urandom_range(2, 255));
			return make_request(iface, 24'($urandom));
		end
		iface = $urandom_range(0, 1) ? IFACE_B : IFACE_A;
		pick = $urandom_range(0, 9);
		if (pick < 3) begin
			n = 14'($urandom_range(0, 3));
		end else if (pick < 5) begin
			n = 14'($urandom_range(0, 64));
		end else begin
			n = 14'($urandom);
		end
		return make_request(iface, {6'($urandom), 1'($urandom), 3'($urandom), n});
	endfunction

	// Hold the item until the block takes it; valid stays up for the next one.
	task automatic send_request(input bdd_in_t req);
		in_valid <= 1'b1;
		in_data <= req;
		do @(posedge clk); while (!in_ready);
		requests_sent++;
	endtask

	// End a burst now and then with a random gap.
	task automatic pace_sender();
		int gap;
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 30);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	// Hold off until every expected result has come, with a limit.
	task automatic wait_drained();
		int spins;
		spins = 0;
		@(posedge clk);
		while (pending != 0 && spins < DRAIN_LIMIT) begin
			@(posedge clk);
			spins++;
		end
	endtask

	initial begin
		bdd_in_t directed[$];
		int k;
		// Zero divisor, one-and-a-half, refused interfaces.
		directed.push_back(make_request(IFACE_A, 24'h000000));
		directed.push_back(make_request(IFACE_B, 24'h020000));
		directed.push_back(make_request(8'h02, 24'hFF1234));
		directed.push_back(make_request(IFACE_A, 24'h000001));
		directed.push_back(make_request(IFACE_B, 24'h020001));
		directed.push_back(make_request(8'hFF, 24'h000000));
		// Fraction with zero integer part, every nonzero fraction code.
		for (k = 1; k < 8; k++) begin
			directed.push_back(make_request(IFACE_A, {6'd0, 1'(k % 2), 3'(k), 14'd0}));
		end
		// Largest divisors, unused high bits, all ones.
		directed.push_back(make_request(IFACE_A, 24'h01FFFF));
		directed.push_back(make_request(IFACE_B, 24'h03FFFF));
		directed.push_back(make_request(IFACE_B, 24'hFC001A));
		directed.push_back(make_request(IFACE_A, 24'hFFFFFF));
		directed.push_back(make_request(8'h80, 24'hFFFFFF));
		directed.push_back(make_request(IFACE_A, 24'h000002));
		directed.push_back(make_request(IFACE_B, 24'h024003));
		directed.push_back(make_request(8'hFE, 24'h00FFFF));
		directed.push_back(make_request(IFACE_A, 24'h001A0D));

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (directed[i]) begin
			send_request(directed[i]);
			pace_sender();
		end
		// Let the block drain fully before the random part.
		in_valid <= 1'b0;
		wait_drained();

		for (k = 0; k < RANDOM_REQUESTS; k++) begin
			send_request(random_request());
			if (k == RANDOM_REQUESTS / 2) begin
				in_valid <= 1'b0;
				wait_drained();
			end else begin
				pace_sender();
			end
		end
		in_valid <= 1'b0;
		wait_drained();
		repeat (40) @(posedge clk);

		$display("Sent %0d requests, %0d changed the rate; %0d results checked.",
			requests_sent, rate_changes, checked);
		if (pending != 0) begin
			$display("%0t: %0d expected results never arrived", $time, pending);
		end
		if (fail_count == 0 && pending == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	// Stop a hung run.
	initial begin
		#10_000_000;
		$display("%0t: run timed out", $time);
		$display("Test completed with failures");
		$finish;
	end

endmodule
